FILE: sv/dsfp_pkg.sv
// Shared types and constants for the dust sensor frame parser.
package dsfp_pkg;

	// Configuration register indexes.
	localparam logic [1:0] REG_HEADER_FIRST  = 2'd0;
	localparam logic [1:0] REG_HEADER_SECOND = 2'd1;
	localparam logic [1:0] REG_PM_OFFSET     = 2'd2;
	localparam logic [1:0] REG_DUST_OFFSET   = 2'd3;

	// Reset values of the configuration registers.
	localparam logic [7:0] HEADER_FIRST_RST  = 8'h42;
	localparam logic [7:0] HEADER_SECOND_RST = 8'h4d;
	localparam logic [4:0] PM_OFFSET_RST     = 5'd12;
	localparam logic [4:0] DUST_OFFSET_RST   = 5'd18;

	// Current configuration as seen by the frame logic.
	typedef struct packed {
		logic [7:0] header_first;
		logic [7:0] header_second;
		logic [4:0] pm_offset;
		logic [4:0] dust_offset;
	} cfg_t;

	// One finished frame as reported by the frame logic.
	typedef struct packed {
		logic        valid;
		logic [15:0] pm_value;
		logic [15:0] dust_value;
		logic        checksum_ok;
	} frame_res_t;

endpackage

FILE: sv/dsfp_frame_core.sv
// Frame state, header hunt, checksum and reading capture for one byte a cycle while en is high.
module dsfp_frame_core #(
	parameter int FRAME_LENGTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic [7:0]          rx_byte,
	input  dsfp_pkg::cfg_t      cfg,
	output dsfp_pkg::frame_res_t res
);

	localparam int POS_W = $clog2(FRAME_LENGTH);
	localparam int CMP_W = (POS_W > 6) ? POS_W : 6;
	localparam logic [POS_W:0]   FRAME_LEN_EXT = (POS_W + 1)'(FRAME_LENGTH);
	localparam logic [POS_W-1:0] CHK_HI_POS    = POS_W'(FRAME_LENGTH - 2);
	localparam logic [POS_W-1:0] FIRST_POS     = POS_W'(1);

	logic [POS_W-1:0] pos_q, pos_nxt;
	logic [15:0]      sum_q, sum_nxt;
	logic [15:0]      rd1_q, rd1_nxt;
	logic [15:0]      rd2_q, rd2_nxt;
	logic [7:0]       chk_hi_q, chk_hi_nxt;

	// Place a byte into the high or low half of a reading when the position matches.
	function automatic logic [15:0] cap_word(input logic [15:0] cur,
			input logic [CMP_W-1:0] p, input logic [4:0] off, input logic [7:0] b);
		logic [CMP_W-1:0] hi_at;
		logic [CMP_W-1:0] lo_at;
		logic [15:0]      w;
		hi_at = CMP_W'(off);
		lo_at = CMP_W'(off) + CMP_W'(1);
		w = cur;
		if (p == hi_at) begin
			w = {b, w[7:0]};
		end
		if (p == lo_at) begin
			w = {w[15:8], b};
		end
		return w;
	endfunction

	// Next state and result for the byte at hand.
	always_comb begin
		logic start;
		logic hunt;
		start      = 1'b0;
		hunt       = ({1'b0, pos_q} >= FRAME_LEN_EXT) || (pos_q == '0);
		pos_nxt    = pos_q;
		sum_nxt    = sum_q;
		rd1_nxt    = rd1_q;
		rd2_nxt    = rd2_q;
		chk_hi_nxt = chk_hi_q;
		res.valid       = 1'b0;
		res.pm_value    = rd1_q;
		res.dust_value  = rd2_q;
		res.checksum_ok = 1'b0;

		if (hunt) begin
			pos_nxt = '0;
			start   = (rx_byte == cfg.header_first);
		end else if ((pos_q == FIRST_POS) && (rx_byte != cfg.header_second)) begin
			pos_nxt = '0;
			start   = (rx_byte == cfg.header_first);
		end else begin
			rd1_nxt = cap_word(rd1_q, CMP_W'(pos_q), cfg.pm_offset, rx_byte);
			rd2_nxt = cap_word(rd2_q, CMP_W'(pos_q), cfg.dust_offset, rx_byte);
			if (pos_q < CHK_HI_POS) begin
				sum_nxt = sum_q + {8'h00, rx_byte};
				pos_nxt = pos_q + FIRST_POS;
			end else if (pos_q == CHK_HI_POS) begin
				chk_hi_nxt = rx_byte;
				pos_nxt    = pos_q + FIRST_POS;
			end else begin
				// Last byte of the frame: report and go back to hunting.
				res.valid       = 1'b1;
				res.pm_value    = rd1_nxt;
				res.dust_value  = rd2_nxt;
				res.checksum_ok = ({chk_hi_q, rx_byte} == sum_q);
				pos_nxt         = '0;
				sum_nxt         = '0;
			end
		end

		// A header byte opens a new frame at position zero.
		if (start) begin
			rd1_nxt    = cap_word(16'h0000, '0, cfg.pm_offset, rx_byte);
			rd2_nxt    = cap_word(16'h0000, '0, cfg.dust_offset, rx_byte);
			chk_hi_nxt = 8'h00;
			sum_nxt    = {8'h00, rx_byte};
			pos_nxt    = FIRST_POS;
		end
	end

	// Frame position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (en) begin
			pos_q <= pos_nxt;
		end
	end

	// Sum, readings and checksum high byte; all are set when a frame opens.
	always_ff @(posedge clk) begin
		if (en) begin
			sum_q    <= sum_nxt;
			rd1_q    <= rd1_nxt;
			rd2_q    <= rd2_nxt;
			chk_hi_q <= chk_hi_nxt;
		end
	end

endmodule

FILE: sv/dust_sensor_frame_parser_unit.sv
// Top level of the dust sensor frame parser: stream ports, configuration and output word.
// Takes one received sensor byte per word and frames the stream into packets of
// FRAME_LENGTH bytes that start with two configurable header bytes. After the last
// byte of a packet it sends one word with the two big-endian readings taken from the
// configured offsets and a flag telling whether the sum of the leading bytes matched
// the trailing checksum. Every byte is held in the input register and passes through
// the frame logic into the output register, so a new byte is taken in every cycle as
// long as the output side keeps up; a result word is offered once the last byte of its
// packet has moved from the input register through the frame logic into the output
// register. Configuration writes are meant for idle time.
module dust_sensor_frame_parser_unit #(
	parameter int FRAME_LENGTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port.
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [7:0]  cfg_wdata,
	// Received bytes.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	// Frame results.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [15:0] pm_value, [31:16] dust_value
	output logic [0:0]  m_axis_tuser    // [0] checksum_ok
);

	dsfp_pkg::cfg_t       cfg_q;
	dsfp_pkg::frame_res_t res;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        adv;
	logic        out_free;
	logic        out_valid_q;
	logic [31:0] out_data_q;
	logic        out_ok_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_first  <= dsfp_pkg::HEADER_FIRST_RST;
			cfg_q.header_second <= dsfp_pkg::HEADER_SECOND_RST;
			cfg_q.pm_offset     <= dsfp_pkg::PM_OFFSET_RST;
			cfg_q.dust_offset   <= dsfp_pkg::DUST_OFFSET_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				dsfp_pkg::REG_HEADER_FIRST:  cfg_q.header_first  <= cfg_wdata;
				dsfp_pkg::REG_HEADER_SECOND: cfg_q.header_second <= cfg_wdata;
				dsfp_pkg::REG_PM_OFFSET:     cfg_q.pm_offset     <= cfg_wdata[4:0];
				dsfp_pkg::REG_DUST_OFFSET:   cfg_q.dust_offset   <= cfg_wdata[4:0];
				default: ;
			endcase
		end
	end

	// Handshake: the held byte moves on unless it ends a frame and the output word is full.
	assign out_free      = !out_valid_q || m_axis_tready;
	assign adv           = valid_s1 && (!res.valid || out_free);
	assign s_axis_tready = !valid_s1 || adv;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	dsfp_frame_core #(
		.FRAME_LENGTH(FRAME_LENGTH)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.rx_byte (byte_s1),
		.cfg     (cfg_q),
		.res     (res)
	);

	// Output word register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && res.valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.valid) begin
			out_data_q <= {res.dust_value, res.pm_value};
			out_ok_q   <= res.checksum_ok;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_ok_q;

endmodule

FILE: tb/dust_sensor_frame_parser_checker.sv
// Checker for the dust sensor frame parser: tracks configuration, predicts and compares words.
module dust_sensor_frame_parser_checker #(
	parameter int FRAME_LENGTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [7:0]  cfg_wdata,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [31:0] m_axis_tdata,   // [15:0] pm_value, [31:16] dust_value
	input  logic [0:0]  m_axis_tuser,   // [0] checksum_ok
	output int          mismatches,
	output int          outstanding
);

	// One predicted result word.
	typedef struct packed {
		logic [15:0] pm_value;
		logic [15:0] dust_value;
		logic        checksum_ok;
	} reading_t;

	reading_t readings_due[$];

	// Local copy of the configuration registers.
	logic [7:0] hdr_a;
	logic [7:0] hdr_b;
	logic [4:0] pm_off;
	logic [4:0] dust_off;

	// Frame tracking state.
	logic [5:0]  next_pos;
	logic [15:0] sum_so_far;
	logic [15:0] pm_held;
	logic [15:0] dust_held;
	logic [7:0]  sum_hi;

	initial begin
		mismatches  = 0;
		outstanding = 0;
	end

	// Store a byte into whichever reading halves its frame position names.
	function automatic void grab_reading(input int at, input logic [7:0] b);
		if (at == int'(pm_off))
			pm_held[15:8] = b;
		if (at == int'(pm_off) + 1)
			pm_held[7:0] = b;
		if (at == int'(dust_off))
			dust_held[15:8] = b;
		if (at == int'(dust_off) + 1)
			dust_held[7:0] = b;
	endfunction

	// A header byte opens a new packet.
	function automatic void open_frame(input logic [7:0] b);
		pm_held    = '0;
		dust_held  = '0;
		sum_hi     = '0;
		sum_so_far = {8'h00, b};
		grab_reading(0, b);
		next_pos   = 6'd1;
	endfunction

	// Advance the frame tracker by one received byte.
	task automatic track_byte(input logic [7:0] b);
		int       at;
		reading_t r;
		at = int'(next_pos);
		if (at == 0 || at >= FRAME_LENGTH) begin
			next_pos = '0;
			if (b == hdr_a)
				open_frame(b);
			return;
		end
		// A wrong second header byte drops the packet, but may itself begin a new one.
		if (at == 1 && b != hdr_b) begin
			next_pos = '0;
			if (b == hdr_a)
				open_frame(b);
			return;
		end
		grab_reading(at, b);
		if (at < FRAME_LENGTH - 2) begin
			sum_so_far = sum_so_far + {8'h00, b};
			next_pos   = 6'(at + 1);
		end else if (at == FRAME_LENGTH - 2) begin
			sum_hi   = b;
			next_pos = 6'(at + 1);
		end else begin
			r.pm_value    = pm_held;
			r.dust_value  = dust_held;
			r.checksum_ok = ({sum_hi, b} == sum_so_far);
			readings_due.push_back(r);
			next_pos   = '0;
			sum_so_far = '0;
		end
	endtask

	// Compare one result word with the oldest prediction.
	task automatic check_reading();
		reading_t want;
		if (readings_due.size() == 0) begin
			$display("%0t: unexpected result word, actual data %h flag %b",
				$time, m_axis_tdata, m_axis_tuser);
			mismatches++;
			return;
		end
		want = readings_due.pop_front();
		if (m_axis_tdata[15:0] !== want.pm_value) begin
			$display("%0t: pm_value expected %h, actual %h",
				$time, want.pm_value, m_axis_tdata[15:0]);
			mismatches++;
		end
		if (m_axis_tdata[31:16] !== want.dust_value) begin
			$display("%0t: dust_value expected %h, actual %h",
				$time, want.dust_value, m_axis_tdata[31:16]);
			mismatches++;
		end
		if (m_axis_tuser[0] !== want.checksum_ok) begin
			$display("%0t: checksum_ok expected %b, actual %b",
				$time, want.checksum_ok, m_axis_tuser[0]);
			mismatches++;
		end
	endtask

	// Watch the configuration port and both word channels.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_a      = dsfp_pkg::HEADER_FIRST_RST;
			hdr_b      = dsfp_pkg::HEADER_SECOND_RST;
			pm_off     = dsfp_pkg::PM_OFFSET_RST;
			dust_off   = dsfp_pkg::DUST_OFFSET_RST;
			next_pos   = '0;
			sum_so_far = '0;
			pm_held    = '0;
			dust_held  = '0;
			sum_hi     = '0;
			readings_due.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					dsfp_pkg::REG_HEADER_FIRST: begin
						hdr_a = cfg_wdata;
					end
					dsfp_pkg::REG_HEADER_SECOND: begin
						hdr_b = cfg_wdata;
					end
					dsfp_pkg::REG_PM_OFFSET: begin
						pm_off = cfg_wdata[4:0];
					end
					dsfp_pkg::REG_DUST_OFFSET: begin
						dust_off = cfg_wdata[4:0];
					end
					default: begin
					end
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				track_byte(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready)
				check_reading();
		end
		outstanding = readings_due.size();
	end

endmodule

FILE: tb/dust_sensor_frame_parser_unit_test.sv
// Testbench top for the dust sensor frame parser: clock, reset, stimulus and verdict.
module dust_sensor_frame_parser_unit_test;

	localparam int FRAME_LENGTH = 32;

	// Payload patterns for generated frames.
	typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        cfg_we        = 1'b0;
	logic [1:0]  cfg_addr      = dsfp_pkg::REG_HEADER_FIRST;
	logic [7:0]  cfg_wdata     = 8'h00;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] rx_byte
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;            // [15:0] pm_value, [31:16] dust_value
	logic [0:0]  m_axis_tuser;            // [0] checksum_ok

	int mismatches;
	int outstanding;

	// Stimulus bookkeeping and the header values currently in use.
	bit         calm = 1'b0;
	int         bytes_sent = 0;
	int         frames_sent = 0;
	int         spins;
	int         pick;
	logic [7:0] cur_hdr_a = dsfp_pkg::HEADER_FIRST_RST;
	logic [7:0] cur_hdr_b = dsfp_pkg::HEADER_SECOND_RST;

	dust_sensor_frame_parser_unit #(
		.FRAME_LENGTH(FRAME_LENGTH)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	dust_sensor_frame_parser_checker #(
		.FRAME_LENGTH(FRAME_LENGTH)
	) i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	// Clock with a period of four time units.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// The result side stalls at random except during the calm stretch.
	always @(negedge clk) begin
		m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 31);
	end

	// Offer one byte word, with random gaps before it, and wait until it is taken.
	task automatic send_byte(input logic [7:0] b);
		@(negedge clk);
		while (!calm && $urandom_range(99) < 31) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= 8'($urandom_range(255));
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		bytes_sent++;
	endtask

	// Send one complete packet with the current headers and a right or wrong checksum.
	task automatic send_frame(input fill_t fill, input bit sum_good);
		logic [15:0] total;
		logic [15:0] trailer;
		logic [7:0]  b;
		total = '0;
		for (int k = 0; k < FRAME_LENGTH - 2; k++) begin
			if (k == 0)
				b = cur_hdr_a;
			else if (k == 1)
				b = cur_hdr_b;
			else if (fill == FILL_ZERO)
				b = 8'h00;
			else if (fill == FILL_ONES)
				b = 8'hFF;
			else
				b = 8'($urandom_range(255));
			total = total + {8'h00, b};
			send_byte(b);
		end
		trailer = sum_good ? total : (total ^ 16'($urandom_range(1, 16'hFFFF)));
		send_byte(trailer[15:8]);
		send_byte(trailer[7:0]);
		frames_sent++;
	endtask

	// Let every predicted word arrive and the pipeline drain before touching registers.
	task automatic settle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Write all four registers while the block is idle.
	task automatic write_config(input logic [7:0] h1, input logic [7:0] h2,
			input logic [4:0] pm, input logic [4:0] dust);
		logic [7:0] vals[4];
		logic [1:0] regs[4];
		vals = '{h1, h2, {3'b000, pm}, {3'b000, dust}};
		regs = '{dsfp_pkg::REG_HEADER_FIRST, dsfp_pkg::REG_HEADER_SECOND,
			dsfp_pkg::REG_PM_OFFSET, dsfp_pkg::REG_DUST_OFFSET};
		settle();
		for (int k = 0; k < 4; k++) begin
			@(negedge clk);
			cfg_we    <= 1'b1;
			cfg_addr  <= regs[k];
			cfg_wdata <= vals[k];
		end
		@(negedge clk);
		cfg_we    <= 1'b0;
		cur_hdr_a = h1;
		cur_hdr_b = h2;
	endtask

	// Pick a random offset, now and then outside the data area.
	function automatic logic [4:0] any_offset();
		if ($urandom_range(99) < 20)
			return 5'($urandom_range(31));
		return 5'($urandom_range(28, 2));
	endfunction

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part under the reset configuration first.
		send_byte(8'h00);
		send_frame(FILL_ONES, 1'b1);
		send_frame(FILL_ZERO, 1'b1);
		send_frame(FILL_RANDOM, 1'b0);
		// A repeated first header byte restarts the packet.
		send_byte(cur_hdr_a);
		send_frame(FILL_RANDOM, 1'b1);
		// A wrong second header byte sends the parser back to hunting.
		send_byte(cur_hdr_a);
		send_byte(cur_hdr_b ^ 8'h01);
		send_frame(FILL_RANDOM, 1'b1);

		// Header extremes and offsets on the header, checksum and past the frame end.
		write_config(8'h00, 8'hFF, 5'd0, 5'd31);
		send_frame(FILL_ONES, 1'b1);
		write_config(8'hFF, 8'h00, 5'd30, 5'd29);
		send_frame(FILL_RANDOM, 1'b1);
		write_config(8'hA5, 8'hA5, 5'd2, 5'd28);
		send_frame(FILL_RANDOM, 1'b0);
		write_config(dsfp_pkg::HEADER_FIRST_RST, dsfp_pkg::HEADER_SECOND_RST,
			dsfp_pkg::PM_OFFSET_RST, dsfp_pkg::DUST_OFFSET_RST);
		send_frame(FILL_RANDOM, 1'b1);

		// Random part: mostly well-formed packets, some noise and broken packets.
		while (bytes_sent < 900) begin
			calm = (frames_sent >= 20 && frames_sent < 27);
			if (frames_sent % 6 == 0 && $urandom_range(99) < 60) begin
				if ($urandom_range(99) < 30)
					write_config(dsfp_pkg::HEADER_FIRST_RST, dsfp_pkg::HEADER_SECOND_RST,
						any_offset(), any_offset());
				else
					write_config(8'($urandom_range(255)), 8'($urandom_range(255)),
						any_offset(), any_offset());
			end
			pick = $urandom_range(99);
			if (pick < 70) begin
				send_frame($urandom_range(99) < 90 ? FILL_RANDOM : fill_t'($urandom_range(2)),
					$urandom_range(99) < 85);
			end else if (pick < 85) begin
				repeat ($urandom_range(6, 1)) send_byte(8'($urandom_range(255)));
			end else if (pick < 93) begin
				// Packet cut short; the next packet's bytes fill it up.
				send_byte(cur_hdr_a);
				send_byte(cur_hdr_b);
				repeat ($urandom_range(FRAME_LENGTH - 4)) send_byte(8'($urandom_range(255)));
			end else begin
				send_byte(cur_hdr_a);
				send_byte(8'($urandom_range(255)));
			end
		end
		calm = 1'b0;

		// Drain and give the verdict.
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		spins = 0;
		while (outstanding != 0 && spins < 2000) begin
			@(negedge clk);
			spins++;
		end
		repeat (8) @(negedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Hard stop in case the block hangs.
	initial begin
		#400000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
